### rtl/vfps_pkg.sv
package vfps_pkg;

  // Widths of the request and result fields.
  localparam int unsigned DeltaW = 20;
  localparam int unsigned DurW   = 24;
  localparam int unsigned PosW   = 40;
  localparam int unsigned TimeW  = 32;
  localparam int unsigned LimW   = 20;
  localparam int unsigned NosyW  = 27;
  localparam int unsigned ActW   = 3;

  // Configuration port.
  localparam int unsigned CfgAddrW = 2;
  localparam int unsigned CfgDataW = 27;

  localparam logic [CfgAddrW-1:0] CFG_SYNC_MIN     = 2'd0;
  localparam logic [CfgAddrW-1:0] CFG_SYNC_MAX     = 2'd1;
  localparam logic [CfgAddrW-1:0] CFG_FRAMEDUP_LIM = 2'd2;
  localparam logic [CfgAddrW-1:0] CFG_NOSYNC_LIM   = 2'd3;

  // Reset values of the registers and the pacing state.
  localparam logic [LimW-1:0]  SYNC_MIN_RST     = 20'd100;
  localparam logic [LimW-1:0]  SYNC_MAX_RST     = 20'd500000;
  localparam logic [LimW-1:0]  FRAMEDUP_LIM_RST = 20'd100000;
  localparam logic [NosyW-1:0] NOSYNC_LIM_RST   = 27'd10000000;
  localparam logic [TimeW-1:0] TIMER_RST        = 32'd1000000;

  // Sync action codes.
  localparam logic [ActW-1:0] ACT_NONE    = 3'd0;
  localparam logic [ActW-1:0] ACT_CATCHUP = 3'd1;
  localparam logic [ActW-1:0] ACT_LONG    = 3'd2;
  localparam logic [ActW-1:0] ACT_REPEAT  = 3'd3;
  localparam logic [ActW-1:0] ACT_INSYNC  = 3'd4;
  localparam logic [ActW-1:0] ACT_DESYNC  = 3'd5;

  typedef struct packed {
    logic [DeltaW-1:0] delta_us;
    logic              frame_ready;
    logic [DurW-1:0]   frame_duration_us;
    logic [PosW-1:0]   frame_pos_us;
    logic [PosW-1:0]   master_pos_us;
    logic              seeking;
  } vfps_in_t;

  typedef struct packed {
    logic              frame_taken;
    logic [ActW-1:0]   sync_action;
    logic [TimeW-1:0]  next_delay_us;
    logic              underflow;
    logic              all_displayed;
    logic [PosW-1:0]   video_pos_us;
  } vfps_out_t;

endpackage

### rtl/video_frame_pacing_sync.sv
// Channel   Direction  Handshake               Payload
// in_       request    in_valid / in_ready     in_data  (vfps_in_t)
// out_      result     out_valid / out_ready   out_data (vfps_out_t)
// cfg_      write      cfg_we                  cfg_addr, cfg_wdata
//
// Each request is held in the input register and is decided on the way into the
// result register. One request per cycle is sustained while out_ready is high;
// the pacing state updates once per request.
// Reset (synchronous, rst_n low) loads the register defaults and the pacing state.
// A stalled result holds the result register; the input register then fills and
// in_ready drops until out_ready returns.
module video_frame_pacing_sync (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  vfps_pkg::vfps_in_t                   in_data,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output vfps_pkg::vfps_out_t                  out_data,
  input  logic                                 cfg_we,
  input  logic [vfps_pkg::CfgAddrW-1:0]        cfg_addr,
  input  logic [vfps_pkg::CfgDataW-1:0]        cfg_wdata
);
  import vfps_pkg::*;

  // Configuration registers.
  logic [LimW-1:0]  sync_min_r, sync_max_r, framedup_lim_r;
  logic [NosyW-1:0] nosync_lim_r;

  // Pipeline registers.
  logic      s1_valid_r;
  vfps_in_t  s1_r;
  logic      out_valid_r;
  vfps_out_t out_r;

  // Pacing state.
  logic [TimeW-1:0] timer_r, timer_nxt;
  logic [TimeW-1:0] interval_r, interval_nxt;
  logic [PosW-1:0]  shown_pos_r, shown_pos_nxt;
  logic             done_r, done_nxt;
  logic             last_seek_r;

  logic      advance;
  vfps_out_t res;

  logic [TimeW:0]   timer_sum;
  logic [TimeW-1:0] timer_sat;
  logic             due;
  logic [PosW:0]    diff;
  logic [PosW:0]    mag;
  logic [DurW-1:0]  thr_hi;
  logic [DurW-1:0]  thr;
  logic             ge_thr;
  logic             catchup;
  logic [DurW:0]    dur_x;
  logic [NosyW:0]   mag_n;
  logic [NosyW:0]   delay;
  logic [ActW-1:0]  action;

  assign advance   = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready  = !s1_valid_r || advance;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sync_min_r     <= SYNC_MIN_RST;
      sync_max_r     <= SYNC_MAX_RST;
      framedup_lim_r <= FRAMEDUP_LIM_RST;
      nosync_lim_r   <= NOSYNC_LIM_RST;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        CFG_SYNC_MIN:     sync_min_r     <= cfg_wdata[LimW-1:0];
        CFG_SYNC_MAX:     sync_max_r     <= cfg_wdata[LimW-1:0];
        CFG_FRAMEDUP_LIM: framedup_lim_r <= cfg_wdata[LimW-1:0];
        CFG_NOSYNC_LIM:   nosync_lim_r   <= cfg_wdata[NosyW-1:0];
        default:          ;
      endcase
    end
  end

  // Timer accumulation with saturation, and the due check.
  always_comb begin
    timer_sum = {1'b0, timer_r} + {{(TimeW+1-DeltaW){1'b0}}, s1_r.delta_us};
    timer_sat = timer_sum[TimeW] ? {TimeW{1'b1}} : timer_sum[TimeW-1:0];
    due       = timer_sat >= interval_r;
  end

  // Video minus master difference and the clamped sync threshold.
  always_comb begin
    diff   = {1'b0, shown_pos_r} - {1'b0, s1_r.master_pos_us};
    mag    = diff[PosW] ? (~diff + 1'b1) : diff;
    thr_hi = (s1_r.frame_duration_us < {{(DurW-LimW){1'b0}}, sync_max_r}) ?
             s1_r.frame_duration_us : {{(DurW-LimW){1'b0}}, sync_max_r};
    thr    = (thr_hi < {{(DurW-LimW){1'b0}}, sync_min_r}) ?
             {{(DurW-LimW){1'b0}}, sync_min_r} : thr_hi;
    ge_thr = mag >= {{(PosW+1-DurW){1'b0}}, thr};
    // Catch-up covers a zero difference when the threshold is zero too.
    catchup = (diff[PosW] && ge_thr) || ((diff == '0) && (thr == '0));
  end

  // Sync decision and the next interval.
  always_comb begin
    dur_x = {1'b0, s1_r.frame_duration_us};
    mag_n = {1'b0, mag[NosyW-1:0]};
    delay = {{(NosyW+1-DurW){1'b0}}, dur_x[DurW-1:0]};
    if (mag >= {{(PosW+1-NosyW){1'b0}}, nosync_lim_r}) begin
      action = ACT_DESYNC;
    end else if (catchup) begin
      action = ACT_CATCHUP;
      // The magnitude stays below the no-sync limit, so it fits its width.
      delay  = (mag_n > {{(NosyW-DurW){1'b0}}, dur_x}) ? '0 :
               {{(NosyW-DurW){1'b0}}, dur_x} - mag_n;
    end else if (ge_thr && (s1_r.frame_duration_us >
                            {{(DurW-LimW){1'b0}}, framedup_lim_r})) begin
      action = ACT_LONG;
      delay  = {{(NosyW-DurW){1'b0}}, dur_x} + mag_n;
    end else if (ge_thr) begin
      action = ACT_REPEAT;
      delay  = {{(NosyW-DurW){1'b0}}, s1_r.frame_duration_us, 1'b0};
    end else begin
      action = ACT_INSYNC;
    end
  end

  // Next pacing state and the result of this request.
  always_comb begin
    timer_nxt     = timer_sat;
    interval_nxt  = interval_r;
    shown_pos_nxt = shown_pos_r;
    done_nxt      = (s1_r.seeking != last_seek_r) ? 1'b0 : done_r;
    res           = '0;
    res.sync_action = ACT_NONE;
    if (due) begin
      if (s1_r.frame_ready) begin
        timer_nxt       = timer_sat - interval_r;
        interval_nxt    = {{(TimeW-NosyW-1){1'b0}}, delay};
        shown_pos_nxt   = s1_r.frame_pos_us;
        res.frame_taken = 1'b1;
        res.sync_action = action;
      end else if (s1_r.seeking) begin
        done_nxt = 1'b1;
      end else begin
        res.underflow = 1'b1;
      end
    end
    res.next_delay_us = interval_nxt;
    res.all_displayed = done_nxt;
    res.video_pos_us  = shown_pos_nxt;
  end

  // Control state and pipeline valid bits.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      timer_r     <= TIMER_RST;
      interval_r  <= TIMER_RST;
      shown_pos_r <= '0;
      done_r      <= 1'b0;
      last_seek_r <= 1'b0;
    end else begin
      if (in_ready) begin
        s1_valid_r <= in_valid;
      end
      if (advance) begin
        out_valid_r <= 1'b1;
        timer_r     <= timer_nxt;
        interval_r  <= interval_nxt;
        shown_pos_r <= shown_pos_nxt;
        done_r      <= done_nxt;
        last_seek_r <= s1_r.seeking;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s1_r <= in_data;
    end
    if (advance) begin
      out_r <= res;
    end
  end

endmodule

### bench/testbench.sv
`timescale 1ns / 1ps

module testbench;
  import vfps_pkg::*;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                in_valid = 1'b0;
  logic                in_ready;
  vfps_in_t            in_data = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  vfps_out_t           out_data;
  logic                cfg_we = 1'b0;
  logic [CfgAddrW-1:0] cfg_addr = CFG_SYNC_MIN;
  logic [CfgDataW-1:0] cfg_wdata = '0;

  video_frame_pacing_sync u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata)
  );

  // Clock with a 4 ns period.
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Copy of the limit registers, updated as they are written.
  logic [LimW-1:0]  lim_min    = SYNC_MIN_RST;
  logic [LimW-1:0]  lim_max    = SYNC_MAX_RST;
  logic [LimW-1:0]  lim_dup    = FRAMEDUP_LIM_RST;
  logic [NosyW-1:0] lim_nosync = NOSYNC_LIM_RST;

  // Pacing state as the block should hold it.
  logic [TimeW-1:0] pace_timer    = TIMER_RST;
  logic [TimeW-1:0] pace_interval = TIMER_RST;
  logic [PosW-1:0]  pace_shown    = '0;
  logic             pace_done     = 1'b0;
  logic             pace_seek_q   = 1'b0;

  // Event tallies for the closing summary.
  int act_cnt [8] = '{default: 0};
  int under_cnt = 0;
  int sat_cnt = 0;
  int n_ticks = 0;
  int n_results = 0;
  int n_err = 0;

  vfps_in_t  tick_queue [$];
  vfps_out_t due_results [$];

  // Stimulus generator state: a running master clock and the seek state.
  logic [PosW-1:0] gen_master = '0;
  bit              gen_seek = 1'b0;

  // Handshake bookkeeping shared between the monitor and the drivers.
  logic req_taken = 1'b0;
  logic res_taken = 1'b0;
  int   send_wait = -1;
  int   recv_wait = -1;
  bit   quiet_in = 1'b0;
  bit   quiet_out = 1'b0;

  // Advance the pacing state by one tick and return the result it produces.
  function automatic vfps_out_t pace_step(input vfps_in_t rq);
    logic [TimeW:0]     sum;
    logic signed [47:0] dur, diff, mag, thr, delay, lo, hi, dup, nos;
    vfps_out_t          r;
    r = '0;
    dur = {24'd0, rq.frame_duration_us};
    lo  = {28'd0, lim_min};
    hi  = {28'd0, lim_max};
    dup = {28'd0, lim_dup};
    nos = {21'd0, lim_nosync};

    // Any change of the seek input clears the all-displayed flag.
    if (rq.seeking != pace_seek_q) begin
      pace_done = 1'b0;
    end
    pace_seek_q = rq.seeking;

    sum = {1'b0, pace_timer} + (TimeW+1)'(rq.delta_us);
    if (sum[TimeW]) begin
      pace_timer = '1;
      sat_cnt++;
    end else begin
      pace_timer = sum[TimeW-1:0];
    end

    if (pace_timer >= pace_interval) begin
      if (rq.frame_ready) begin
        diff = {8'd0, pace_shown} - {8'd0, rq.master_pos_us};
        mag = (diff < 0) ? -diff : diff;
        thr = (dur < hi) ? dur : hi;
        if (thr < lo) begin
          thr = lo;
        end
        delay = dur;
        pace_timer = pace_timer - pace_interval;

        // Pick the correction from the video-minus-master difference.
        if (mag >= nos) begin
          r.sync_action = ACT_DESYNC;
        end else if (diff <= -thr) begin
          delay = dur + diff;
          if (delay < 0) begin
            delay = 0;
          end
          r.sync_action = ACT_CATCHUP;
        end else if (diff >= thr && dur > dup) begin
          delay = dur + diff;
          r.sync_action = ACT_LONG;
        end else if (diff >= thr) begin
          delay = dur + dur;
          r.sync_action = ACT_REPEAT;
        end else begin
          r.sync_action = ACT_INSYNC;
        end

        pace_interval = (delay > 48'sh0000_FFFF_FFFF) ? '1 : delay[TimeW-1:0];
        pace_shown = rq.frame_pos_us;
        r.frame_taken = 1'b1;
        act_cnt[r.sync_action]++;
      end else if (rq.seeking) begin
        pace_done = 1'b1;
      end else begin
        r.underflow = 1'b1;
        under_cnt++;
      end
    end

    r.next_delay_us = pace_interval;
    r.all_displayed = pace_done;
    r.video_pos_us  = pace_shown;
    return r;
  endfunction

  function automatic vfps_in_t mk_tick(input logic [DeltaW-1:0] delta, input logic ready,
                                       input logic [DurW-1:0] dur, input logic [PosW-1:0] fpos,
                                       input logic [PosW-1:0] mpos, input logic seek);
    vfps_in_t t;
    t.delta_us          = delta;
    t.frame_ready       = ready;
    t.frame_duration_us = dur;
    t.frame_pos_us      = fpos;
    t.master_pos_us     = mpos;
    t.seeking           = seek;
    return t;
  endfunction

  // Random tick: mostly a plausible playback stream around a running master
  // clock, with some fully random noise.
  function automatic vfps_in_t next_tick();
    vfps_in_t    t;
    int          off;
    int unsigned pick;
    t = '0;
    if ($urandom_range(0, 99) < 15) begin
      t.delta_us          = DeltaW'($urandom);
      t.frame_ready       = 1'($urandom);
      t.frame_duration_us = DurW'($urandom);
      t.frame_pos_us      = PosW'({$urandom, $urandom});
      t.master_pos_us     = PosW'({$urandom, $urandom});
      t.seeking           = 1'($urandom);
      return t;
    end

    // A seek toggles now and then and moves the master clock.
    if ($urandom_range(0, 19) == 0) begin
      gen_seek = !gen_seek;
      gen_master = gen_master + $urandom_range(0, 5000000);
    end

    pick = $urandom_range(0, 99);
    if (pick < 70) begin
      t.frame_duration_us = DurW'($urandom_range(10000, 50000));
    end else if (pick < 80) begin
      t.frame_duration_us = DurW'($urandom_range(0, 1000));
    end else if (pick < 95) begin
      t.frame_duration_us = DurW'($urandom_range(100000, 400000));
    end else begin
      t.frame_duration_us = DurW'($urandom);
    end

    t.delta_us = ($urandom_range(0, 19) == 0) ? {DeltaW{1'b1}}
                                                : DeltaW'($urandom_range(0, 60000));
    gen_master = gen_master + t.delta_us;

    // Frame position relative to the master clock: near, a few frames off,
    // far, or beyond any sensible correction.
    pick = $urandom_range(0, 99);
    if (pick < 50) begin
      off = $urandom_range(0, 400) - 200;
    end else if (pick < 75) begin
      off = $urandom_range(0, 4 * t.frame_duration_us) - 2 * t.frame_duration_us;
    end else if (pick < 90) begin
      off = $urandom_range(0, 2000000) - 1000000;
    end else begin
      off = $urandom_range(5000000, 110000000);
      if ($urandom_range(0, 1) == 1) begin
        off = -off;
      end
    end

    t.frame_ready   = ($urandom_range(0, 9) != 0);
    t.master_pos_us = gen_master;
    t.frame_pos_us  = gen_master + {{8{off[31]}}, off};
    t.seeking       = gen_seek;
    return t;
  endfunction

  // Per-request idle draw, with runs where a side does not idle at all.
  function automatic int draw_gap(inout bit quiet);
    if ($urandom_range(0, 39) == 0) begin
      quiet = !quiet;
    end
    return quiet ? 0 : $urandom_range(0, 7);
  endfunction

  task automatic report_err(input string what, input logic [63:0] got,
                            input logic [63:0] want);
    n_err++;
    $display("%0t ns: %s: got %0h, expected %0h", $time, what, got, want);
  endtask

  // Write one limit register and mirror it in the local copy.
  task automatic write_reg(input logic [CfgAddrW-1:0] idx, input int unsigned value);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= CfgDataW'(value);
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_SYNC_MIN:     lim_min = LimW'(value);
      CFG_SYNC_MAX:     lim_max = LimW'(value);
      CFG_FRAMEDUP_LIM: lim_dup = LimW'(value);
      CFG_NOSYNC_LIM:   lim_nosync = NosyW'(value);
      default: ;
    endcase
  endtask

  task automatic set_limits(input int unsigned mn, input int unsigned mx,
                            input int unsigned dup, input int unsigned nos);
    write_reg(CFG_SYNC_MIN, mn);
    write_reg(CFG_SYNC_MAX, mx);
    write_reg(CFG_FRAMEDUP_LIM, dup);
    write_reg(CFG_NOSYNC_LIM, nos);
  endtask

  // Hold off until every queued request is sent and every result is back.
  task automatic wait_quiet();
    while (tick_queue.size() != 0 || in_valid || due_results.size() != 0) begin
      @(negedge clk);
    end
    repeat (4) @(negedge clk);
  endtask

  // Request driver: draws a gap before each request, then holds it until taken.
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || req_taken) begin
      if (tick_queue.size() != 0 && send_wait < 0) begin
        send_wait = draw_gap(quiet_in);
      end
      if (tick_queue.size() != 0 && send_wait == 0) begin
        in_data  <= tick_queue.pop_front();
        in_valid <= 1'b1;
        send_wait = -1;
      end else begin
        in_valid <= 1'b0;
        if (send_wait > 0) begin
          send_wait--;
        end
      end
    end
  end

  // Result receiver: stalls a random number of cycles before each result.
  always @(negedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (!(out_ready && !res_taken)) begin
      if (recv_wait < 0) begin
        recv_wait = draw_gap(quiet_out);
      end
      if (recv_wait == 0) begin
        out_ready <= 1'b1;
        recv_wait = -1;
      end else begin
        out_ready <= 1'b0;
        recv_wait--;
      end
    end
  end

  // Monitor: predicts on each accepted request and checks each accepted result.
  always @(posedge clk) begin : monitor
    vfps_out_t want;
    req_taken <= rst_n && in_valid && in_ready;
    res_taken <= rst_n && out_valid && out_ready;
    if (rst_n && in_valid && in_ready) begin
      due_results.push_back(pace_step(in_data));
      n_ticks++;
    end
    if (rst_n && out_valid && out_ready) begin
      if (due_results.size() == 0) begin
        report_err("result with no request pending", 64'(out_data), 64'd0);
      end else begin
        want = due_results.pop_front();
        n_results++;
        if (out_data.frame_taken !== want.frame_taken)
          report_err("frame_taken", 64'(out_data.frame_taken), 64'(want.frame_taken));
        if (out_data.sync_action !== want.sync_action)
          report_err("sync_action", 64'(out_data.sync_action), 64'(want.sync_action));
        if (out_data.next_delay_us !== want.next_delay_us)
          report_err("next_delay_us", 64'(out_data.next_delay_us),
                     64'(want.next_delay_us));
        if (out_data.underflow !== want.underflow)
          report_err("underflow", 64'(out_data.underflow), 64'(want.underflow));
        if (out_data.all_displayed !== want.all_displayed)
          report_err("all_displayed", 64'(out_data.all_displayed),
                     64'(want.all_displayed));
        if (out_data.video_pos_us !== want.video_pos_us)
          report_err("video_pos_us", 64'(out_data.video_pos_us), 64'(want.video_pos_us));
      end
    end
  end

  // Main sequence: reset, directed ticks, random phases, a frameless stretch.
  initial begin : stimulus
    int unsigned k;
    int unsigned j;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed ticks under the reset limits.
    tick_queue.push_back(mk_tick('0, 1'b1, 24'd33333, 40'd0, 40'd0, 1'b0));
    tick_queue.push_back(mk_tick('0, 1'b1, 24'd33333, 40'd33333, 40'd0, 1'b0));
    tick_queue.push_back(mk_tick('1, 1'b0, '0, '0, '0, 1'b0));
    tick_queue.push_back(mk_tick(20'd1, 1'b0, '0, '0, '0, 1'b1));
    tick_queue.push_back(mk_tick('0, 1'b0, '0, '0, '0, 1'b1));
    tick_queue.push_back(mk_tick('0, 1'b0, '0, '0, '0, 1'b0));
    tick_queue.push_back(mk_tick('0, 1'b1, 24'd40000, 40'd1000000, 40'd200000, 1'b0));
    tick_queue.push_back(mk_tick('0, 1'b1, 24'd20000, 40'd2000000, 40'd900000, 1'b0));
    tick_queue.push_back(mk_tick('1, 1'b1, 24'd200000, 40'd50000000, 40'd1700000, 1'b0));
    tick_queue.push_back(mk_tick('1, 1'b1, 24'd50000, '1, 40'd0, 1'b0));
    tick_queue.push_back(mk_tick('1, 1'b1, 24'd0, 40'd0, 40'd0, 1'b0));
    tick_queue.push_back(mk_tick('1, 1'b1, 24'd0, 40'd5000, '1, 1'b0));
    // Threshold boundaries with a zero duration (threshold is the minimum).
    tick_queue.push_back(mk_tick('0, 1'b1, 24'd0, 40'd5050, 40'd4900, 1'b0));
    tick_queue.push_back(mk_tick('0, 1'b1, 24'd0, 40'd6000, 40'd5100, 1'b0));
    tick_queue.push_back(mk_tick('0, 1'b1, 24'd0, 40'd1000000, 40'd6100, 1'b0));
    // Just above and exactly at the frame-duplication limit.
    tick_queue.push_back(mk_tick('0, 1'b1, 24'd100001, 40'd2000000, 40'd899999, 1'b0));
    tick_queue.push_back(mk_tick('1, 1'b1, 24'd100000, 40'd3000000, 40'd1900000, 1'b0));
    // Difference exactly at and just under the no-sync limit.
    tick_queue.push_back(mk_tick('1, 1'b1, 24'd1000, 40'd4000000, 40'd13000000, 1'b0));
    tick_queue.push_back(mk_tick('1, 1'b1, 24'd1000, 40'd5000000, 40'd13999999, 1'b0));
    tick_queue.push_back(mk_tick('1, 1'b1, '1, '1, 40'd5000000, 1'b0));
    tick_queue.push_back(mk_tick('0, 1'b1, 24'd1000, 40'd77, 40'd88, 1'b1));
    tick_queue.push_back(mk_tick('1, 1'b0, 24'd1000, 40'd77, 40'd88, 1'b0));
    wait_quiet();

    // Random phases, each under its own limit setting.
    for (k = 0; k < 7; k++) begin
      case (k)
        0: set_limits(0, 1000000, 0, 100000000);
        1: set_limits(1000000, 0, 1000000, 5000);
        2: set_limits(0, 0, 50000, 0);
        6: set_limits(32'(SYNC_MIN_RST), 32'(SYNC_MAX_RST), 32'(FRAMEDUP_LIM_RST),
                      32'(NOSYNC_LIM_RST));
        default: set_limits($urandom_range(0, 2000), $urandom_range(1000, 1000000),
                            $urandom_range(0, 1000000), $urandom_range(1000, 100000000));
      endcase
      gen_master = PosW'({$urandom, $urandom}) >> $urandom_range(0, 39);
      for (j = 0; j < 95; j++) begin
        tick_queue.push_back(next_tick());
      end
      wait_quiet();
    end

    // A stretch without frames piles time into the timer, with seeks in
    // between, then frames resume.
    for (j = 0; j < 24; j++) begin
      tick_queue.push_back(mk_tick('1, 1'b0, DurW'($urandom), PosW'({$urandom, $urandom}),
                                   PosW'({$urandom, $urandom}), (j % 8) > 5));
    end
    for (j = 0; j < 20; j++) begin
      tick_queue.push_back(next_tick());
    end
    wait_quiet();

    $display("Summary: %0d ticks, %0d results checked over 8 limit settings,",
             n_ticks, n_results);
    $display("  %0d timer saturations.", sat_cnt);
    $display("Frames: %0d catch-up, %0d long, %0d repeat, %0d in sync,",
             act_cnt[ACT_CATCHUP], act_cnt[ACT_LONG], act_cnt[ACT_REPEAT],
             act_cnt[ACT_INSYNC]);
    $display("  %0d desync; %0d underflows.", act_cnt[ACT_DESYNC], under_cnt);
    if (n_err == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  // Watchdog for a hung handshake.
  initial begin
    #3000000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule

### filelist.f
rtl/vfps_pkg.sv
rtl/video_frame_pacing_sync.sv
bench/testbench.sv
